/* hdl/fis_pkg.sv */
// Shared types and constants for the frame interval statistics block.
// No dependencies; imported by frame_interval_statistics and fis_checker.
package fis_pkg;

  localparam int unsigned DefaultDepth = 256;
  localparam int unsigned StampW       = 63;
  localparam int unsigned DivW         = 48;
  localparam int unsigned PaddrW       = 4;

  localparam logic [31:0] RateSat          = 32'hFFFF_FFFF;
  localparam logic [31:0] TickRateReset    = 32'd10_000_000;
  localparam logic [31:0] MinIntervalReset = 32'd166_667;
  localparam logic [31:0] WindowReset      = 32'd2_500_000;

  typedef enum logic [1:0] {
    REG_TICK_RATE    = 2'd0,
    REG_MIN_INTERVAL = 2'd1,
    REG_WINDOW       = 2'd2
  } fis_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_CLASSIFY,
    ST_RATE_DIV,
    ST_STORE,
    ST_WALK,
    ST_MEAN_DIV,
    ST_FINISH
  } fis_state_e;

endpackage

/* hdl/frame_interval_statistics.sv */
// Frame interval statistics. Each input beat carries a 63-bit timestamp. A
// beat spaced at least min_interval_ticks after the last frame counts a frame:
// its interval (saturated to 32 bits) and its rate tick_rate/interval in 16.16
// go into a ring RAM of HISTORY_DEPTH entries, and the ring is walked from
// the newest entry until the summed intervals reach window_ticks, giving the
// min, max and mean rate. A timestamp below the last one counts a frame at the
// newest stored interval and leaves the ring alone. Every input beat gives one
// output beat. A beat that counts no frame or goes backwards passes through
// the idle, diff, classify and finish states. A new frame also runs the rate
// division, the store, a one-entry-a-cycle RAM walk over the ring entries
// inside the window (at most HISTORY_DEPTH) and the mean division, both on the
// shared 48-step restoring divider. A zero interval or one of 2^48 ticks or
// more skips the rate division. A result that waits for the receiver stalls
// the input. One beat is in work at a time. Only written ring entries
// are read (a fill count bounds the walk), so the RAM needs no clearing pass.
// Registers over APB: tick_rate at 0x0, min_interval_ticks at 0x4,
// window_ticks at 0x8; write only while idle.
module frame_interval_statistics
  import fis_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = DefaultDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // APB configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PaddrW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // timestamp beats
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [StampW-1:0]  timestamp_i,
  // result beats
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               arrived_o,
  output logic               wrapped_o,
  output logic [31:0]        frame_ticks_o,
  output logic [31:0]        fps_now_o,
  output logic [31:0]        fps_mean_o,
  output logic [31:0]        fps_least_o,
  output logic [31:0]        fps_most_o,
  output logic [63:0]        frames_total_o,
  output logic [63:0]        elapsed_total_o
);

  localparam int unsigned AW  = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SW  = 32 + CW;   // rate sum and tick sum width

  // ---------------- configuration ----------------
  logic [31:0] tick_rate_q, min_iv_q, window_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_rate_q <= TickRateReset;
      min_iv_q    <= MinIntervalReset;
      window_q    <= WindowReset;
    end else if (cfg_we) begin
      case (fis_reg_e'(paddr[3:2]))
        REG_TICK_RATE:    tick_rate_q <= pwdata;
        REG_MIN_INTERVAL: min_iv_q    <= pwdata;
        REG_WINDOW:       window_q    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (fis_reg_e'(paddr[3:2]))
      REG_TICK_RATE:    prdata = tick_rate_q;
      REG_MIN_INTERVAL: prdata = min_iv_q;
      REG_WINDOW:       prdata = window_q;
      default:          prdata = '0;
    endcase
  end

  // ---------------- state ----------------
  fis_state_e state_q, state_d;

  logic [StampW-1:0] ts_q, ts_d, last_q, last_d;
  logic [StampW-1:0] diff_q, diff_d;
  logic              wrap_q, wrap_d;
  logic [AW-1:0]     slot_q, slot_d;
  logic [CW-1:0]     filled_q, filled_d;
  logic [63:0]       frames_q, frames_d, elapsed_q, elapsed_d;
  logic [31:0]       mean_q, mean_d, low_q, low_d, high_q, high_d;
  logic [31:0]       now_rate_q, now_rate_d, now_iv_q, now_iv_d;
  logic [31:0]       rate_q, rate_d, iv_q, iv_d;
  logic              res_arr_q, res_arr_d, res_wrap_q, res_wrap_d;
  logic [31:0]       res_ticks_q, res_ticks_d;

  // ring walk
  logic [AW-1:0]     rd_addr_q, rd_addr_d;
  logic [CW-1:0]     issued_q, issued_d, taken_q, taken_d;
  logic              pend_q, pend_d;
  logic [SW-1:0]     rsum_q, rsum_d, tsum_q, tsum_d;
  logic [31:0]       lo_q, lo_d, hi_q, hi_d;

  // shared restoring divider
  logic [DivW:0]     div_rem_q, div_rem_d;
  logic [DivW-1:0]   div_num_q, div_num_d, div_den_q, div_den_d;
  logic [5:0]        div_cnt_q, div_cnt_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              o_arr_q, o_wrap_q;
  logic [31:0]       o_ticks_q, o_now_q, o_mean_q, o_low_q, o_high_q;
  logic [63:0]       o_frames_q, o_elapsed_q;
  logic              out_load;

  // RAM: {rate, interval}
  logic              ram_we;
  logic [63:0]       ram_rdata;

  fis_ram #(
    .WIDTH (64),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i ({rate_q, iv_q}),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  // ---------------- datapath helpers ----------------
  logic [StampW:0]  sub_full;
  logic             frame_ok, rate_special;
  logic [DivW:0]    div_shift;
  logic [DivW+1:0]  div_trial;
  logic             div_ge;
  logic [DivW:0]    div_rem_n;
  logic [DivW-1:0]  div_num_n;
  logic [31:0]      ent_rate, ent_iv, lo_n, hi_n;
  logic [SW-1:0]    rsum_n, tsum_n;
  logic [CW-1:0]    cnt_n;
  logic             walk_done;

  assign sub_full     = {1'b0, ts_q} - {1'b0, last_q};
  assign frame_ok     = diff_q >= StampW'(min_iv_q);
  assign rate_special = (diff_q == '0) || (|diff_q[StampW-1:DivW]);

  assign div_shift = {div_rem_q[DivW-1:0], div_num_q[DivW-1]};
  assign div_trial = {1'b0, div_shift} - {2'b00, div_den_q};
  assign div_ge    = !div_trial[DivW+1];
  assign div_rem_n = div_ge ? div_trial[DivW:0] : div_shift;
  assign div_num_n = {div_num_q[DivW-2:0], div_ge};

  assign ent_rate  = ram_rdata[63:32];
  assign ent_iv    = ram_rdata[31:0];
  assign rsum_n    = rsum_q + SW'(ent_rate);
  assign tsum_n    = tsum_q + SW'(ent_iv);
  assign cnt_n     = taken_q + CW'(1);
  assign lo_n      = (ent_rate < lo_q) ? ent_rate : lo_q;
  assign hi_n      = (ent_rate > hi_q) ? ent_rate : hi_q;
  // entry that reaches the window is still counted
  assign walk_done = (tsum_n >= SW'(window_q)) || (cnt_n == filled_q);

  assign out_load  = !out_valid_q || out_ready_i;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_DIFF;
      ST_DIFF:     state_d = ST_CLASSIFY;
      ST_CLASSIFY: begin
        if (wrap_q || !frame_ok) state_d = ST_FINISH;
        else if (rate_special)   state_d = ST_STORE;
        else                     state_d = ST_RATE_DIV;
      end
      ST_RATE_DIV: if (div_cnt_q == '0) state_d = ST_STORE;
      ST_STORE:    state_d = ST_WALK;
      ST_WALK:     if (pend_q && walk_done) state_d = ST_MEAN_DIV;
      ST_MEAN_DIV: if (div_cnt_q == '0) state_d = ST_FINISH;
      ST_FINISH:   if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // ---------------- datapath / outputs ----------------
  always_comb begin
    ts_d        = ts_q;
    last_d      = last_q;
    diff_d      = diff_q;
    wrap_d      = wrap_q;
    slot_d      = slot_q;
    filled_d    = filled_q;
    frames_d    = frames_q;
    elapsed_d   = elapsed_q;
    mean_d      = mean_q;
    low_d       = low_q;
    high_d      = high_q;
    now_rate_d  = now_rate_q;
    now_iv_d    = now_iv_q;
    rate_d      = rate_q;
    iv_d        = iv_q;
    res_arr_d   = res_arr_q;
    res_wrap_d  = res_wrap_q;
    res_ticks_d = res_ticks_q;
    rd_addr_d   = rd_addr_q;
    issued_d    = issued_q;
    taken_d     = taken_q;
    pend_d      = pend_q;
    rsum_d      = rsum_q;
    tsum_d      = tsum_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    div_rem_d   = div_rem_q;
    div_num_d   = div_num_q;
    div_den_d   = div_den_q;
    div_cnt_d   = div_cnt_q;
    ram_we      = 1'b0;
    in_ready_o  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ts_d       = timestamp_i;
      end
      ST_DIFF: begin
        diff_d = sub_full[StampW-1:0];
        wrap_d = sub_full[StampW];
      end
      ST_CLASSIFY: begin
        if (wrap_q) begin
          // backwards stamp: count a frame at the newest stored interval
          res_arr_d   = 1'b1;
          res_wrap_d  = 1'b1;
          res_ticks_d = now_iv_q;
          frames_d    = frames_q + 64'd1;
          elapsed_d   = elapsed_q + {32'd0, now_iv_q};
          last_d      = ts_q;
        end else if (frame_ok) begin
          iv_d        = (|diff_q[StampW-1:32]) ? RateSat : diff_q[31:0];
          res_arr_d   = 1'b1;
          res_wrap_d  = 1'b0;
          res_ticks_d = (|diff_q[StampW-1:32]) ? RateSat : diff_q[31:0];
          frames_d    = frames_q + 64'd1;
          elapsed_d   = elapsed_q + {1'b0, diff_q};
          last_d      = ts_q;
          // zero interval saturates; an interval beyond the dividend gives 0
          rate_d      = (diff_q == '0) ? RateSat : '0;
          div_rem_d   = '0;
          div_num_d   = {tick_rate_q, 16'd0};
          div_den_d   = diff_q[DivW-1:0];
          div_cnt_d   = 6'(DivW - 1);
        end else begin
          res_arr_d   = 1'b0;
          res_wrap_d  = 1'b0;
          res_ticks_d = '0;
        end
      end
      ST_RATE_DIV: begin
        div_rem_d = div_rem_n;
        div_num_d = div_num_n;
        div_cnt_d = div_cnt_q - 6'd1;
        if (div_cnt_q == '0) begin
          rate_d = (|div_num_n[DivW-1:32]) ? RateSat : div_num_n[31:0];
        end
      end
      ST_STORE: begin
        ram_we     = 1'b1;
        now_rate_d = rate_q;
        now_iv_d   = iv_q;
        slot_d     = (slot_q == AW'(HISTORY_DEPTH - 1)) ? '0 : slot_q + AW'(1);
        if (filled_q != CW'(HISTORY_DEPTH)) filled_d = filled_q + CW'(1);
        rd_addr_d  = slot_q;
        issued_d   = '0;
        taken_d    = '0;
        pend_d     = 1'b0;
        rsum_d     = '0;
        tsum_d     = '0;
        lo_d       = RateSat;
        hi_d       = '0;
      end
      ST_WALK: begin
        if (pend_q) begin
          rsum_d  = rsum_n;
          tsum_d  = tsum_n;
          taken_d = cnt_n;
          lo_d    = lo_n;
          hi_d    = hi_n;
        end
        if (pend_q && walk_done) begin
          pend_d    = 1'b0;
          low_d     = lo_n;
          high_d    = hi_n;
          div_rem_d = '0;
          div_num_d = DivW'(rsum_n);
          div_den_d = DivW'(cnt_n);
          div_cnt_d = 6'(DivW - 1);
        end else if (issued_q < filled_q) begin
          // RAM reads rd_addr_q this cycle; step to the next older entry
          pend_d    = 1'b1;
          issued_d  = issued_q + CW'(1);
          rd_addr_d = (rd_addr_q == '0) ? AW'(HISTORY_DEPTH - 1) : rd_addr_q - AW'(1);
        end else begin
          pend_d = 1'b0;
        end
      end
      ST_MEAN_DIV: begin
        div_rem_d = div_rem_n;
        div_num_d = div_num_n;
        div_cnt_d = div_cnt_q - 6'd1;
        if (div_cnt_q == '0) mean_d = div_num_n[31:0];
      end
      ST_FINISH: ;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == ST_FINISH && out_load) out_valid_d = 1'b1;
    else if (out_ready_i)                 out_valid_d = 1'b0;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      last_q      <= '0;
      slot_q      <= '0;
      filled_q    <= '0;
      frames_q    <= '0;
      elapsed_q   <= '0;
      mean_q      <= '0;
      low_q       <= '0;
      high_q      <= '0;
      now_rate_q  <= '0;
      now_iv_q    <= '0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      slot_q      <= slot_d;
      filled_q    <= filled_d;
      frames_q    <= frames_d;
      elapsed_q   <= elapsed_d;
      mean_q      <= mean_d;
      low_q       <= low_d;
      high_q      <= high_d;
      now_rate_q  <= now_rate_d;
      now_iv_q    <= now_iv_d;
      pend_q      <= pend_d;
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    ts_q        <= ts_d;
    diff_q      <= diff_d;
    wrap_q      <= wrap_d;
    rate_q      <= rate_d;
    iv_q        <= iv_d;
    res_arr_q   <= res_arr_d;
    res_wrap_q  <= res_wrap_d;
    res_ticks_q <= res_ticks_d;
    rd_addr_q   <= rd_addr_d;
    issued_q    <= issued_d;
    taken_q     <= taken_d;
    rsum_q      <= rsum_d;
    tsum_q      <= tsum_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    div_rem_q   <= div_rem_d;
    div_num_q   <= div_num_d;
    div_den_q   <= div_den_d;
    div_cnt_q   <= div_cnt_d;
    if (state_q == ST_FINISH && out_load) begin
      o_arr_q     <= res_arr_q;
      o_wrap_q    <= res_wrap_q;
      o_ticks_q   <= res_ticks_q;
      o_now_q     <= now_rate_q;
      o_mean_q    <= mean_q;
      o_low_q     <= low_q;
      o_high_q    <= high_q;
      o_frames_q  <= frames_q;
      o_elapsed_q <= elapsed_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign arrived_o       = o_arr_q;
  assign wrapped_o       = o_wrap_q;
  assign frame_ticks_o   = o_ticks_q;
  assign fps_now_o       = o_now_q;
  assign fps_mean_o      = o_mean_q;
  assign fps_least_o     = o_low_q;
  assign fps_most_o      = o_high_q;
  assign frames_total_o  = o_frames_q;
  assign elapsed_total_o = o_elapsed_q;

endmodule

/* hdl/fis_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fis_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/fis_checker.sv */
// Port-level checks for frame_interval_statistics, bound to the top level.
// Depends on fis_pkg.
module fis_checker
  import fis_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               arrived_o,
  input logic               wrapped_o,
  input logic [31:0]        frame_ticks_o,
  input logic [31:0]        fps_mean_o,
  input logic [31:0]        fps_least_o,
  input logic [31:0]        fps_most_o,
  input logic [63:0]        frames_total_o
);

  logic        seen_q;
  logic [63:0] frames_prev_q;
  logic        out_beat;

  assign out_beat = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q        <= 1'b0;
      frames_prev_q <= '0;
    end else if (out_beat) begin
      seen_q        <= 1'b1;
      frames_prev_q <= frames_total_o;
    end
  end

  // frame count steps by exactly one per counted frame
  a_frames_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && seen_q |-> frames_total_o == frames_prev_q + {63'd0, arrived_o})
    else $error("frames_total does not follow arrived");

  // a beat with no frame reports no interval and no wrap
  a_no_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !arrived_o |-> !wrapped_o && frame_ticks_o == '0)
    else $error("no-frame beat carries frame data");

  // window statistics stay ordered
  a_stats_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fps_least_o <= fps_mean_o && fps_mean_o <= fps_most_o)
    else $error("window statistics out of order");

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frames_total_o))
    else $error("result beat dropped before accept");

endmodule

bind frame_interval_statistics fis_checker u_fis_checker (.*);
